// File: hw/rtl/xor_frame_checker_top_defines.svh
// Assertion macros shared by the frame checker RTL.
// Included by files that carry concurrent assertions; needs no other file.
`ifndef XOR_FRAME_CHECKER_TOP_DEFINES_SVH
`define XOR_FRAME_CHECKER_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define XFC_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define XFC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: hw/rtl/xfc_pkg.sv
// Package for the XOR frame checker: constants, status codes and shared types.
// Used by every RTL module of the block; depends on nothing.
package xfc_pkg;

   localparam int unsigned ByteWidth  = 8;
   localparam int unsigned CountWidth = 9;

   localparam logic [CountWidth-1:0] CountMax  = 9'd511;
   localparam logic [CountWidth-1:0] LeadBytes = 9'd3;
   localparam logic [CountWidth-1:0] MinFrame  = 9'd5;

   typedef enum logic [2:0] {
      STATUS_OK       = 3'd0,
      STATUS_SHORT    = 3'd1,
      STATUS_FRAMING  = 3'd2,
      STATUS_LENGTH   = 3'd3,
      STATUS_CHECKSUM = 3'd4
   } frame_status_type;

   typedef enum logic {
      KIND_PAYLOAD = 1'b0,
      KIND_VERDICT = 1'b1
   } item_kind_type;

   typedef enum logic [0:0] {
      CSR_HEADER = 1'b0,
      CSR_TAIL   = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [ByteWidth-1:0] header_value;
      logic [ByteWidth-1:0] tail_value;
   } csr_type;

   typedef struct packed {
      item_kind_type        item_kind;
      logic [ByteWidth-1:0] payload_value;
      logic [ByteWidth-1:0] payload_position;
      logic [ByteWidth-1:0] command_code;
      logic [ByteWidth-1:0] payload_count;
      frame_status_type     frame_status;
      logic                 frame_good;
   } rsp_item_type;

endpackage

// File: hw/rtl/xfc_if.sv
// Valid/ready channel interfaces for the request bytes and the result items.
// Stand-alone; the top level and its neighbours connect through these.
interface xfc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] byte_in;
   logic       final_byte;

   modport source (output valid, output byte_in, output final_byte, input ready);
   modport sink   (input valid, input byte_in, input final_byte, output ready);
endinterface

interface xfc_rsp_if;
   logic       valid;
   logic       ready;
   logic       item_kind;
   logic [7:0] payload_value;
   logic [7:0] payload_position;
   logic [7:0] command_code;
   logic [7:0] payload_count;
   logic [2:0] frame_status;
   logic       frame_good;

   modport source (output valid, output item_kind, output payload_value,
                   output payload_position, output command_code, output payload_count,
                   output frame_status, output frame_good, input ready);
   modport sink   (input valid, input item_kind, input payload_value,
                   input payload_position, input command_code, input payload_count,
                   input frame_status, input frame_good, output ready);
endinterface

// File: hw/rtl/xor_frame_checker_top.sv
// Top level of the XOR frame checker: input register, parser, result register.
// Depends on xfc_pkg, xfc_if, xfc_csr, xfc_parse and the assertion macro header.
//
//   channel   direction  handshake          payload
//   req_port  in         valid/ready        byte_in, final_byte
//   rsp_port  out        valid/ready        item_kind .. frame_good
//   csr_*     in         write enable only  csr_index, csr_wdata
//
// One byte is taken in every cycle while results drain; a result is offered from the result
// register once its byte has passed the input register, and transfers while ready is high.
// Bytes that fall outside the payload and are not final give no result.
// Reset is synchronous: header 170, tail 85, frame state cleared, both stages empty.
// A stalled result holds the result register and, through it, the input register.
`include "xor_frame_checker_top_defines.svh"

module xor_frame_checker_top
   import xfc_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   xfc_req_if.sink              req_port,
   xfc_rsp_if.source            rsp_port,
   input  logic                 csr_write_en,
   input  logic [0:0]           csr_index,
   input  logic [ByteWidth-1:0] csr_wdata
);

   csr_type              cfg;
   logic                 s1_valid_ff, s1_valid_in;
   logic [ByteWidth-1:0] s1_byte_ff;
   logic                 s1_final_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_item_type         rsp_item_ff;
   rsp_item_type         parse_item;
   logic                 parse_produce;
   logic                 advance;
   logic                 move;
   logic                 req_take;

   xfc_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .cfg          (cfg)
   );

   xfc_parse u_parse (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .step       (move),
      .byte_in    (s1_byte_ff),
      .final_byte (s1_final_ff),
      .produce    (parse_produce),
      .item       (parse_item)
   );

   // The result register is free when empty or when its transfer completes now.
   assign advance  = !rsp_valid_ff || rsp_port.ready;
   assign move     = s1_valid_ff && advance;
   assign req_port.ready = !s1_valid_ff || advance;
   assign req_take = req_port.valid && req_port.ready;

   assign s1_valid_in  = req_take || (s1_valid_ff && !advance);
   assign rsp_valid_in = advance ? (move && parse_produce) : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_byte_ff  <= req_port.byte_in;
         s1_final_ff <= req_port.final_byte;
      end
      if (move && parse_produce) begin
         rsp_item_ff <= parse_item;
      end
   end

   assign rsp_port.valid            = rsp_valid_ff;
   assign rsp_port.item_kind        = rsp_item_ff.item_kind;
   assign rsp_port.payload_value    = rsp_item_ff.payload_value;
   assign rsp_port.payload_position = rsp_item_ff.payload_position;
   assign rsp_port.command_code     = rsp_item_ff.command_code;
   assign rsp_port.payload_count    = rsp_item_ff.payload_count;
   assign rsp_port.frame_status     = rsp_item_ff.frame_status;
   assign rsp_port.frame_good       = rsp_item_ff.frame_good;

   `XFC_ASSERT_NOW(a_verdict_good, clock, reset, rsp_valid_ff && (rsp_item_ff.item_kind == KIND_VERDICT), rsp_item_ff.frame_good == (rsp_item_ff.frame_status == STATUS_OK), "frame_good disagrees with frame_status")
   `XFC_ASSERT_NOW(a_payload_clean, clock, reset, rsp_valid_ff && (rsp_item_ff.item_kind == KIND_PAYLOAD), !rsp_item_ff.frame_good && (rsp_item_ff.frame_status == STATUS_OK), "payload item carries verdict fields")
   `XFC_ASSERT_NEXT(a_take_loads, clock, reset, req_take, s1_valid_ff, "accepted byte not held in the input register")
   `XFC_ASSERT_NEXT(a_result_loads, clock, reset, move && parse_produce, rsp_valid_ff, "parser result lost")

endmodule

// File: hw/rtl/xfc_csr.sv
// Configuration registers of the frame checker: header and tail byte values.
// Depends on xfc_pkg.
module xfc_csr
   import xfc_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_write_en,
   input  logic [0:0]           csr_index,
   input  logic [ByteWidth-1:0] csr_wdata,
   output csr_type              cfg
);

   csr_type cfg_ff;
   csr_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_HEADER: cfg_in.header_value = csr_wdata;
            CSR_TAIL:   cfg_in.tail_value   = csr_wdata;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.header_value <= 8'd170;
         cfg_ff.tail_value   <= 8'd85;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// File: hw/rtl/xfc_parse.sv
// Frame parser: per-frame state and the single-pass decision for one byte.
// Depends on xfc_pkg; fed by the input stage of the top level.
module xfc_parse
   import xfc_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  csr_type              cfg,
   input  logic                 step,
   input  logic [ByteWidth-1:0] byte_in,
   input  logic                 final_byte,
   output logic                 produce,
   output rsp_item_type         item
);

   logic [CountWidth-1:0] bytes_seen_ff, bytes_seen_in;
   logic                  header_matched_ff, header_matched_in;
   logic [ByteWidth-1:0]  held_command_ff, held_command_in;
   logic [ByteWidth-1:0]  held_length_ff, held_length_in;
   logic [ByteWidth-1:0]  running_xor_ff, running_xor_in;
   logic [ByteWidth-1:0]  received_check_ff, received_check_in;

   logic [CountWidth-1:0] lead_end;
   logic [CountWidth-1:0] length_target;
   logic                  in_payload;
   frame_status_type      status;

   assign lead_end   = {1'b0, held_length_ff} + LeadBytes;
   assign in_payload = (bytes_seen_ff >= LeadBytes) && (bytes_seen_ff < lead_end);

   // Field capture by position; the first three places take precedence.
   always_comb begin
      header_matched_in = header_matched_ff;
      held_command_in   = held_command_ff;
      held_length_in    = held_length_ff;
      running_xor_in    = running_xor_ff;
      received_check_in = received_check_ff;
      if (bytes_seen_ff == 9'd0) begin
         header_matched_in = (byte_in == cfg.header_value);
      end else if (bytes_seen_ff == 9'd1) begin
         held_command_in = byte_in;
         running_xor_in  = byte_in;
      end else if (bytes_seen_ff == 9'd2) begin
         held_length_in = byte_in;
         running_xor_in = running_xor_ff ^ byte_in;
      end else if (in_payload) begin
         running_xor_in = running_xor_ff ^ byte_in;
      end else if (bytes_seen_ff == lead_end) begin
         received_check_in = byte_in;
      end
      bytes_seen_in = (bytes_seen_ff != CountMax) ? bytes_seen_ff + 9'd1 : bytes_seen_ff;
   end

   // The frame size counts the final byte, so the checks use the updated state.
   assign length_target = {1'b0, held_length_in} + MinFrame;

   always_comb begin
      if (bytes_seen_in < MinFrame) begin
         status = STATUS_SHORT;
      end else if (!header_matched_in || (byte_in != cfg.tail_value)) begin
         status = STATUS_FRAMING;
      end else if (bytes_seen_in != length_target) begin
         status = STATUS_LENGTH;
      end else if (running_xor_in != received_check_in) begin
         status = STATUS_CHECKSUM;
      end else begin
         status = STATUS_OK;
      end
   end

   always_comb begin
      item.item_kind        = KIND_PAYLOAD;
      item.payload_value    = '0;
      item.payload_position = '0;
      item.command_code     = '0;
      item.payload_count    = '0;
      item.frame_status     = STATUS_OK;
      item.frame_good       = 1'b0;
      if (final_byte) begin
         item.item_kind     = KIND_VERDICT;
         item.command_code  = held_command_in;
         item.payload_count = held_length_in;
         item.frame_status  = status;
         item.frame_good    = (status == STATUS_OK);
      end else begin
         item.payload_value    = byte_in;
         item.payload_position = ByteWidth'(bytes_seen_ff - LeadBytes);
      end
   end

   assign produce = final_byte || in_payload;

   always_ff @(posedge clock) begin
      if (reset) begin
         bytes_seen_ff     <= '0;
         header_matched_ff <= 1'b0;
         held_command_ff   <= '0;
         held_length_ff    <= '0;
         running_xor_ff    <= '0;
         received_check_ff <= '0;
      end else if (step) begin
         if (final_byte) begin
            bytes_seen_ff     <= '0;
            header_matched_ff <= 1'b0;
            held_command_ff   <= '0;
            held_length_ff    <= '0;
            running_xor_ff    <= '0;
            received_check_ff <= '0;
         end else begin
            bytes_seen_ff     <= bytes_seen_in;
            header_matched_ff <= header_matched_in;
            held_command_ff   <= held_command_in;
            held_length_ff    <= held_length_in;
            running_xor_ff    <= running_xor_in;
            received_check_ff <= received_check_in;
         end
      end
   end

endmodule

// File: tb/xfc_result_checker.sv
// Result checker for the XOR frame checker: tracks the configuration writes, predicts
// the payload and verdict items for every byte transfer and compares the result transfers.
// Needs xfc_pkg and the channel interfaces of xfc_if.
`timescale 1ns / 1ps

module xfc_result_checker
   import xfc_pkg::*;
#(
   parameter logic [ByteWidth-1:0] HeaderReset = 8'd170,
   parameter logic [ByteWidth-1:0] TailReset   = 8'd85
) (
   input  logic                 clock,
   input  logic                 reset,
   xfc_req_if                   req_mon,
   xfc_rsp_if                   rsp_mon,
   input  logic                 csr_write_en,
   input  logic [0:0]           csr_index,
   input  logic [ByteWidth-1:0] csr_wdata,
   output int                   mismatch_count,
   output int                   pending_count
);

   localparam int PrintLimit = 40;

   logic [ByteWidth-1:0]  cur_header;
   logic [ByteWidth-1:0]  cur_tail;
   logic [CountWidth-1:0] frame_bytes;
   logic                  header_hit;
   logic [ByteWidth-1:0]  cmd_byte;
   logic [ByteWidth-1:0]  len_byte;
   logic [ByteWidth-1:0]  xor_acc;
   logic [ByteWidth-1:0]  check_byte;
   rsp_item_type          items_due[$];
   int                    errors = 0;

   task automatic report_mismatch(input string line);
      errors++;
      // Later mismatches are counted but not printed.
      if (errors <= PrintLimit) $display("%0t ns: mismatch: %s", $time, line);
   endtask

   task automatic clear_frame();
      frame_bytes = '0;
      header_hit  = 1'b0;
      cmd_byte    = '0;
      len_byte    = '0;
      xor_acc     = '0;
      check_byte  = '0;
   endtask

   // Advances the frame parser by one byte and queues the item that the byte causes.
   task automatic parse_byte(input logic [ByteWidth-1:0] b, input logic fin);
      int               pos;
      int               payload_end;
      rsp_item_type     item;
      frame_status_type st;
      pos         = int'(frame_bytes);
      payload_end = int'(LeadBytes) + int'(len_byte);
      item        = '0;
      if (pos == 0) begin
         header_hit = (b == cur_header);
      end else if (pos == 1) begin
         cmd_byte = b;
         xor_acc  = b;
      end else if (pos == 2) begin
         len_byte = b;
         xor_acc  = xor_acc ^ b;
      end else if (pos < payload_end) begin
         xor_acc = xor_acc ^ b;
         if (!fin) begin
            item.item_kind        = KIND_PAYLOAD;
            item.payload_value    = b;
            item.payload_position = 8'(pos - int'(LeadBytes));
            items_due.push_back(item);
         end
      end else if (pos == payload_end) begin
         check_byte = b;
      end
      if (frame_bytes != CountMax) frame_bytes = frame_bytes + 1'b1;
      if (fin) begin
         if (frame_bytes < MinFrame) st = STATUS_SHORT;
         else if (!header_hit || b != cur_tail) st = STATUS_FRAMING;
         else if (frame_bytes != CountWidth'(len_byte) + MinFrame) st = STATUS_LENGTH;
         else if (xor_acc != check_byte) st = STATUS_CHECKSUM;
         else st = STATUS_OK;
         item.item_kind     = KIND_VERDICT;
         item.command_code  = cmd_byte;
         item.payload_count = len_byte;
         item.frame_status  = st;
         item.frame_good    = (st == STATUS_OK);
         items_due.push_back(item);
         clear_frame();
      end
   endtask

   task automatic check_field(input string name, input logic [7:0] got,
                              input logic [7:0] want);
      if (got !== want) begin
         report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
      end
   endtask

   task automatic check_result();
      rsp_item_type want;
      if (items_due.size() == 0) begin
         report_mismatch($sformatf("result transfer of kind %0d with nothing expected",
                                   rsp_mon.item_kind));
      end else begin
         want = items_due.pop_front();
         check_field("item_kind", 8'(rsp_mon.item_kind), 8'(want.item_kind));
         check_field("payload_value", rsp_mon.payload_value, want.payload_value);
         check_field("payload_position", rsp_mon.payload_position, want.payload_position);
         check_field("command_code", rsp_mon.command_code, want.command_code);
         check_field("payload_count", rsp_mon.payload_count, want.payload_count);
         check_field("frame_status", 8'(rsp_mon.frame_status), 8'(want.frame_status));
         check_field("frame_good", 8'(rsp_mon.frame_good), 8'(want.frame_good));
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         cur_header = HeaderReset;
         cur_tail   = TailReset;
         clear_frame();
         items_due.delete();
      end else begin
         if (csr_write_en) begin
            if (csr_index == CSR_HEADER) cur_header = csr_wdata;
            else cur_tail = csr_wdata;
         end
         if (req_mon.valid && req_mon.ready) parse_byte(req_mon.byte_in, req_mon.final_byte);
         if (rsp_mon.valid && rsp_mon.ready) check_result();
      end
      mismatch_count <= errors;
      pending_count  <= items_due.size();
   end

endmodule

// File: tb/xor_frame_checker_top_tb.sv
// Testbench top for the XOR frame checker: clock, reset, frame stimulus, register writes,
// back-pressure and the final verdict. Needs xfc_pkg, xfc_if, the block and xfc_result_checker.
`timescale 1ns / 1ps

module xor_frame_checker_top_tb;
   import xfc_pkg::*;

   localparam int HalfPeriod         = 10;
   localparam logic [7:0] HeaderReset = 8'd170;
   localparam logic [7:0] TailReset   = 8'd85;
   localparam int PhaseBytes         = 150;
   localparam int HoldCycles         = 300;
   localparam int DrainLimit         = 4000;
   localparam int SettleCycles       = 8;

   typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_MOSTLY} rx_pattern_type;

   logic                 clock;
   logic                 reset;
   logic                 csr_write_en;
   logic [0:0]           csr_index;
   logic [ByteWidth-1:0] csr_wdata;
   int                   mismatch_count;
   int                   pending_count;

   logic [7:0]     hdr_now;
   logic [7:0]     tail_now;
   logic [7:0]     frame_q[$];
   int             sent_bytes = 0;
   int             burst_left = 0;
   logic           gaps_off = 1'b0;
   logic           hold_request = 1'b0;
   int             hold_left = 0;
   rx_pattern_type rx_mode = RX_OPEN;
   int             rx_left = 0;
   int             rx_tick = 0;

   xfc_req_if req_bus();
   xfc_rsp_if rsp_bus();

   xor_frame_checker_top dut (
      .clock        (clock),
      .reset        (reset),
      .req_port     (req_bus),
      .rsp_port     (rsp_bus),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   xfc_result_checker #(
      .HeaderReset (HeaderReset),
      .TailReset   (TailReset)
   ) result_check (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_bus),
      .rsp_mon        (rsp_bus),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count)
   );

   always #HalfPeriod clock = ~clock;

   // The receiver changes its stall pattern now and then; a requested hold-off blocks
   // every result transfer for a long stretch so that the block backs up to its input.
   always @(posedge clock) begin
      if (hold_left != 0) begin
         hold_left--;
         rsp_bus.ready <= 1'b0;
      end else if (hold_request) begin
         hold_request = 1'b0;
         hold_left    = HoldCycles;
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rx_left == 0) begin
            rx_mode = rx_pattern_type'($urandom_range(0, 3));
            rx_left = $urandom_range(8, 80);
         end else begin
            rx_left--;
         end
         rx_tick++;
         case (rx_mode)
            RX_OPEN:   rsp_bus.ready <= 1'b1;
            RX_COIN:   rsp_bus.ready <= 1'($urandom_range(0, 1));
            RX_SPARSE: rsp_bus.ready <= (rx_tick % 4 == 0);
            default:   rsp_bus.ready <= ($urandom_range(0, 7) != 0);
         endcase
      end
   end

   function automatic logic [7:0] rand_byte();
      return 8'($urandom);
   endfunction

   task automatic put_byte(input logic [7:0] b, input logic fin);
      req_bus.valid      <= 1'b1;
      req_bus.byte_in    <= b;
      req_bus.final_byte <= fin;
      @(posedge clock);
      while (req_bus.ready !== 1'b1) @(posedge clock);
      sent_bytes++;
      if (!gaps_off) begin
         if (burst_left == 0) begin
            req_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
            burst_left = $urandom_range(1, 24);
         end else begin
            burst_left--;
         end
      end
   endtask

   task automatic send_frame();
      for (int i = 0; i < frame_q.size(); i++) put_byte(frame_q[i], i == frame_q.size() - 1);
   endtask

   // Builds header, command, length, payload, checksum, extra bytes and tail; flip spoils
   // the checksum and a non-zero keep cuts the frame short after that many bytes.
   task automatic build_frame(input logic [7:0] hdr, input logic [7:0] cmd,
                              input logic [7:0] len, input logic [7:0] flip,
                              input logic [7:0] tail, input int extra, input int keep);
      logic [7:0] sum;
      logic [7:0] p;
      frame_q.delete();
      frame_q.push_back(hdr);
      frame_q.push_back(cmd);
      frame_q.push_back(len);
      sum = cmd ^ len;
      for (int i = 0; i < int'(len); i++) begin
         p = rand_byte();
         frame_q.push_back(p);
         sum = sum ^ p;
      end
      frame_q.push_back(sum ^ flip);
      repeat (extra) frame_q.push_back(rand_byte());
      frame_q.push_back(tail);
      if (keep != 0) begin
         while (frame_q.size() > keep) void'(frame_q.pop_back());
      end
   endtask

   task automatic random_frame();
      int         kind;
      logic [7:0] len;
      logic [7:0] flip;
      kind = $urandom_range(0, 99);
      len  = ($urandom_range(0, 19) == 0) ? rand_byte() : 8'($urandom_range(0, 10));
      flip = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(1, 255)) : 8'h00;
      if (kind < 70) begin
         build_frame(hdr_now, rand_byte(), len, flip, tail_now, 0, 0);
      end else if (kind < 78) begin
         build_frame(rand_byte(), rand_byte(), len, flip,
                     $urandom_range(0, 1) ? tail_now : rand_byte(), 0, 0);
      end else if (kind < 86) begin
         build_frame(hdr_now, rand_byte(), len, flip, tail_now, 0,
                     $urandom_range(1, int'(len) + 5));
      end else if (kind < 93) begin
         build_frame(hdr_now, rand_byte(), len, flip, tail_now, $urandom_range(1, 4), 0);
      end else begin
         frame_q.delete();
         repeat ($urandom_range(1, 8)) frame_q.push_back(rand_byte());
      end
      send_frame();
   endtask

   task automatic random_phase(input int count);
      int stop;
      stop     = sent_bytes + count;
      gaps_off = ($urandom_range(0, 3) == 0);
      while (sent_bytes < stop) random_frame();
      gaps_off = 1'b0;
   endtask

   // Waits until every predicted item has been taken or the drain limit runs out, then lets the pipeline settle.
   task automatic wait_idle();
      int waited;
      waited = 0;
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0 && waited < DrainLimit) begin
         @(posedge clock);
         waited++;
      end
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic set_config(input logic [7:0] hdr, input logic [7:0] tail);
      csr_write_en <= 1'b1;
      csr_index    <= CSR_HEADER;
      csr_wdata    <= hdr;
      @(posedge clock);
      csr_index    <= CSR_TAIL;
      csr_wdata    <= tail;
      @(posedge clock);
      csr_write_en <= 1'b0;
      @(posedge clock);
      hdr_now  = hdr;
      tail_now = tail;
   endtask

   initial begin
      #10_000_000;
      $display("[xor_frame_checker_top] ERROR");
      $finish;
   end

   initial begin
      logic [7:0] same;
      clock              = 1'b0;
      reset              = 1'b1;
      csr_write_en       = 1'b0;
      csr_index          = CSR_HEADER;
      csr_wdata          = '0;
      req_bus.valid      = 1'b0;
      req_bus.byte_in    = '0;
      req_bus.final_byte = 1'b0;
      rsp_bus.ready      = 1'b0;
      hdr_now            = HeaderReset;
      tail_now           = TailReset;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed frames under the reset configuration.
      build_frame(HeaderReset, 8'h00, 8'd0, 8'h00, TailReset, 0, 0);
      send_frame();
      frame_q.delete();
      frame_q.push_back(8'hFF);
      send_frame();
      build_frame(HeaderReset, 8'hFF, 8'd2, 8'h00, TailReset, 0, 0);
      send_frame();
      // The final flag falls on the second payload byte, so that byte gives only a verdict.
      build_frame(HeaderReset, 8'h3C, 8'd3, 8'h00, TailReset, 0, 4);
      frame_q.push_back(8'hC3);
      send_frame();
      build_frame(HeaderReset, 8'h11, 8'd0, 8'h00, ~TailReset, 0, 0);
      send_frame();
      build_frame(HeaderReset, 8'h22, 8'd0, 8'h80, TailReset, 0, 0);
      send_frame();
      build_frame(HeaderReset, 8'h33, 8'd0, 8'h00, TailReset, 1, 0);
      send_frame();
      // A short frame still reports the command and length captured so far.
      build_frame(HeaderReset, 8'h44, 8'd1, 8'h00, TailReset, 0, 3);
      send_frame();
      wait_idle();

      set_config(8'h00, 8'hFF);
      gaps_off     = 1'b1;
      hold_request = 1'b1;
      repeat (5) begin
         build_frame(hdr_now, rand_byte(), 8'd8, 8'h00, tail_now, 0, 0);
         send_frame();
      end
      gaps_off = 1'b0;
      random_phase(PhaseBytes);
      wait_idle();

      // One full-size payload, then a frame long enough to saturate the byte count.
      set_config(8'hFF, 8'h00);
      build_frame(hdr_now, rand_byte(), 8'd255, 8'h00, tail_now, 0, 0);
      send_frame();
      build_frame(hdr_now, rand_byte(), 8'd255, 8'h00, tail_now, 260, 0);
      send_frame();
      random_phase(PhaseBytes);
      wait_idle();

      set_config(rand_byte(), rand_byte());
      random_phase(PhaseBytes);
      wait_idle();

      same = rand_byte();
      set_config(same, same);
      random_phase(PhaseBytes);
      wait_idle();

      if (mismatch_count == 0 && pending_count == 0) begin
         $display("[xor_frame_checker_top] OK");
      end else begin
         $display("[xor_frame_checker_top] ERROR");
      end
      $finish;
   end

endmodule
